>>> src/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared types, constants and tables of the MLP inference engine
// Holds the item format passed from front to back, the clamped configuration
// bundle, register and command codes, and the exp/sigmoid lookup tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

	localparam int MAX_LAYERS  = 4;
	localparam int MAX_NEURONS = 32;
	localparam int ROW_LEN     = MAX_NEURONS + 1;
	localparam int MAT_WORDS   = MAX_NEURONS * ROW_LEN;
	localparam int WMEM_DEPTH  = (MAX_LAYERS - 1) * MAT_WORDS;
	localparam int VMEM_DEPTH  = 2 * ROW_LEN;
	localparam int WADDR_W     = $clog2(WMEM_DEPTH);
	localparam int VADDR_W     = $clog2(VMEM_DEPTH);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic signed [15:0] FRAC_ONE = 16'sd4096;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

	// command codes
	localparam logic CMD_WEIGHT = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
	localparam logic [2:0] REG_INPUT_SIZE  = 3'd1;
	localparam logic [2:0] REG_HIDDEN_ONE  = 3'd2;
	localparam logic [2:0] REG_HIDDEN_TWO  = 3'd3;
	localparam logic [2:0] REG_OUTPUT_SIZE = 3'd4;
	localparam logic [2:0] REG_OUTPUT_MODE = 3'd5;

	typedef struct packed {
		logic                cmd;
		logic [WADDR_W-1:0]  waddr;
		logic                elem_we;
		logic [4:0]          elem_idx;
		logic                last;
		logic [5:0]          loaded;
		logic signed [15:0]  data;
	} item_t;

	typedef struct packed {
		logic [2:0] nl;
		logic [5:0] size0;
		logic [5:0] size1;
		logic [5:0] size2;
		logic [5:0] size_out;
		logic       softmax;
	} cfg_t;

	typedef logic [15:0] tab_t [256];

	function automatic logic [5:0] clamp_size(input logic [5:0] s);
		if (s == 6'd0)
			return 6'd1;
		if (s > 6'(MAX_NEURONS))
			return 6'(MAX_NEURONS);
		return s;
	endfunction

	function automatic logic [2:0] clamp_layers(input logic [2:0] n);
		if (n < 3'd2)
			return 3'd2;
		if (n > 3'(MAX_LAYERS))
			return 3'(MAX_LAYERS);
		return n;
	endfunction

	// shift-subtract division, evaluated at elaboration only
	function automatic logic [33:0] udiv34(input logic [33:0] n, input logic [17:0] d);
		logic [34:0] rem;
		logic [33:0] q;
		int i;
		rem = '0;
		q = '0;
		for (i = 33; i >= 0; i--) begin
			rem = {rem[33:0], n[i]};
			if (rem >= {17'b0, d}) begin
				rem = rem - {17'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tab_t build_exp();
		tab_t t;
		logic [63:0] e;
		logic [63:0] r;
		int i;
		e = 64'd1 << 32;
		for (i = 0; i < 256; i++) begin
			r = (e + 64'd32768) >> 16;
			t[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
			e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	function automatic tab_t build_sig();
		tab_t ex;
		tab_t t;
		logic [17:0] d;
		logic [33:0] q;
		int i;
		ex = build_exp();
		for (i = 0; i < 256; i++) begin
			if (i >= 128)
				d = 18'd65536 + {2'b0, ex[i-128]};
			else
				d = 18'd65536 + {2'b0, ex[128-i]};
			q = udiv34(34'h1_0000_0000 + {17'b0, d[17:1]}, d);
			if (i >= 128)
				t[i] = (q > 34'd65535) ? 16'hFFFF : q[15:0];
			else
				t[i] = (q >= 34'd65536) ? 16'h0000 : 16'(34'd65536 - q);
		end
		return t;
	endfunction

	localparam tab_t EXP_TAB = build_exp();
	localparam tab_t SIG_TAB = build_sig();

endpackage

`default_nettype wire

>>> src/mie_div.sv
// ----------------------------------------------------------------------------
// mie_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, 33 steps per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num,
	input  wire logic [20:0] den,
	output logic             done,
	output logic [32:0]      quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [20:0] rem_q;
	logic [20:0] den_q;
	logic [32:0] quo_q;
	logic [21:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[32]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? 21'(trial - {1'b0, den_q}) : trial[20:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

>>> src/mie_front.sv
// ----------------------------------------------------------------------------
// mie_front: item intake and classification
// Accepts items, drops weight writes to bad addresses, forms weight addresses
// and sample positions, and holds classified items in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic               command,
	input  wire logic [1:0]         layer_sel,
	input  wire logic [4:0]         row_sel,
	input  wire logic [5:0]         col_sel,
	input  wire logic signed [15:0] data_value,
	input  wire logic               last_element,
	output logic                    q_valid,
	output mie_pkg::item_t          q_item,
	input  wire logic               q_pop
);

	mie_pkg::item_t            fifo_q [mie_pkg::QDEPTH];
	logic [mie_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mie_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mie_pkg::QPTR_W:0]   count_q;
	logic [5:0]                 elem_cnt_q;
	logic [5:0]                 elem_next;
	logic                       accept;
	logic                       addr_ok;
	logic                       push;
	mie_pkg::item_t             item;

	assign item_ready = count_q != (mie_pkg::QPTR_W+1)'(mie_pkg::QDEPTH);
	assign accept     = item_valid && item_ready;
	assign addr_ok    = (layer_sel < 2'(mie_pkg::MAX_LAYERS - 1))
		&& (col_sel <= 6'(mie_pkg::MAX_NEURONS));
	assign push       = accept && (command == mie_pkg::CMD_SAMPLE || addr_ok);
	assign elem_next  = (elem_cnt_q == 6'd63) ? elem_cnt_q : elem_cnt_q + 6'd1;

	always_comb begin
		item.cmd      = command;
		// layer * 1056 + row * 33 + col, as shifts and adds
		item.waddr    = {layer_sel, 10'b0} + {5'b0, layer_sel, 5'b0}
			+ {2'b0, row_sel, 5'b0} + {7'b0, row_sel} + {6'b0, col_sel};
		item.elem_we  = elem_cnt_q < 6'(mie_pkg::MAX_NEURONS);
		item.elem_idx = elem_cnt_q[4:0];
		item.last     = last_element;
		item.loaded   = elem_next;
		item.data     = data_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			elem_cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop)
				count_q <= count_q + 1'b1;
			else if (!push && q_pop)
				count_q <= count_q - 1'b1;
			if (accept && command == mie_pkg::CMD_SAMPLE)
				elem_cnt_q <= last_element ? 6'd0 : elem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item;
	end

	assign q_valid = count_q != '0;
	assign q_item  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> src/mie_back.sv
// ----------------------------------------------------------------------------
// mie_back: execution engine
// Stores weights and layer values, runs the shared MAC over each neuron,
// applies the activations and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mie_pkg::cfg_t  cfg,
	input  wire logic           q_valid,
	input  wire mie_pkg::item_t q_item,
	output logic                q_pop,
	output logic                result_valid,
	input  wire logic           result_ready,
	output logic [4:0]          neuron_index,
	output logic [15:0]         activation,
	output logic [4:0]          best_class,
	output logic                last
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAC  = 4'd1;
	localparam logic [3:0] S_WAIT = 4'd2;
	localparam logic [3:0] S_FIN  = 4'd3;
	localparam logic [3:0] S_SUM  = 4'd4;
	localparam logic [3:0] S_OUT  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	localparam int WA = mie_pkg::WADDR_W;
	localparam int VA = mie_pkg::VADDR_W;

	logic [3:0]  state_q;
	logic [1:0]  l_q;
	logic        src_q;
	logic [4:0]  r_q;
	logic [5:0]  k_q;
	logic [5:0]  loaded_q;
	logic [WA-1:0] layer_base_q;
	logic [WA-1:0] row_base_q;

	logic signed [15:0] wmem [mie_pkg::WMEM_DEPTH];
	logic signed [15:0] vmem [mie_pkg::VMEM_DEPTH];
	logic signed [15:0] w_rd_q;
	logic signed [15:0] v_rd_q;

	logic        wm_we;
	logic [WA-1:0] wm_waddr;
	logic [WA-1:0] wm_raddr;
	logic        vm_we;
	logic [VA-1:0] vm_waddr;
	logic [VA-1:0] vm_raddr;
	logic signed [15:0] vm_wdata;

	logic        valid_s1, bias_s1, mask_s1, last_s1;
	logic        valid_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic signed [15:0] opnd;
	logic signed [39:0] acc_q;
	logic        acc_done_q;
	logic signed [40:0] acc_rnd;
	logic signed [15:0] z;
	logic [15:0] sig_z;
	logic [15:0] hid;

	logic signed [15:0] zs_q [mie_pkg::MAX_NEURONS];
	logic signed [15:0] zmax_q;
	logic [4:0]  best_q;
	logic [20:0] sum_q;
	logic [15:0] act_q;

	logic [5:0]  src_n;
	logic [5:0]  dst_n;
	logic        is_out;
	logic        row_last;
	logic        res_last;
	logic signed [16:0] zdiff;
	logic [15:0] e_r;
	logic        div_start;
	logic        div_done;
	logic [32:0] div_quo;
	logic        load_out;

	assign is_out   = {1'b0, l_q} == cfg.nl - 3'd2;
	assign src_n    = (l_q == 2'd0) ? cfg.size0 : (l_q == 2'd1 ? cfg.size1 : cfg.size2);
	assign dst_n    = is_out ? cfg.size_out : (l_q == 2'd0 ? cfg.size1 : cfg.size2);
	assign row_last = ({1'b0, r_q} + 6'd1) >= dst_n;
	assign res_last = ({1'b0, r_q} + 6'd1) >= cfg.size_out;

	// round half up to Q4.12, saturate to 16 bits
	assign acc_rnd = {acc_q[39], acc_q} + 41'sd2048;
	always_comb begin
		if (acc_rnd >= 41'sd134217728)
			z = 16'sh7FFF;
		else if (acc_rnd < -41'sd134217728)
			z = -16'sh8000;
		else
			z = acc_rnd[27:12];
	end
	assign sig_z = mie_pkg::SIG_TAB[{~z[15], z[14:8]}];
	assign hid   = {4'b0, 12'((17'(sig_z) + 17'd8) >> 4)};

	assign zdiff = {zmax_q[15], zmax_q} - {zs_q[r_q][15], zs_q[r_q]};
	assign e_r   = mie_pkg::EXP_TAB[zdiff[15:8]];

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign load_out = (state_q == S_EMIT) && (!result_valid || result_ready);
	assign div_start = (state_q == S_OUT) && cfg.softmax;

	// memory ports
	always_comb begin
		wm_we    = q_pop && q_item.cmd == mie_pkg::CMD_WEIGHT;
		wm_waddr = q_item.waddr;
		wm_raddr = row_base_q + WA'(k_q);
		vm_raddr = src_q ? VA'(mie_pkg::ROW_LEN) + VA'(k_q) : VA'(k_q);
		vm_we    = 1'b0;
		vm_waddr = VA'(q_item.elem_idx) + VA'(1);
		vm_wdata = q_item.data;
		if (q_pop && q_item.cmd == mie_pkg::CMD_SAMPLE && q_item.elem_we)
			vm_we = 1'b1;
		if (state_q == S_FIN && !is_out) begin
			vm_we    = 1'b1;
			vm_waddr = (src_q ? VA'(0) : VA'(mie_pkg::ROW_LEN)) + VA'(r_q) + VA'(1);
			vm_wdata = hid;
		end
	end

	always_ff @(posedge clk) begin
		if (wm_we)
			wmem[wm_waddr] <= q_item.data;
		w_rd_q <= wmem[wm_raddr];
	end

	always_ff @(posedge clk) begin
		if (vm_we)
			vmem[vm_waddr] <= vm_wdata;
		v_rd_q <= vmem[vm_raddr];
	end

	// MAC pipeline: read, multiply, accumulate
	always_comb begin
		if (bias_s1)
			opnd = mie_pkg::FRAC_ONE;
		else if (mask_s1)
			opnd = '0;
		else
			opnd = v_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			valid_s1 <= state_q == S_MAC;
			valid_s2 <= valid_s1;
			if (state_q == S_FIN)
				acc_done_q <= 1'b0;
			else if (valid_s2 && last_s2)
				acc_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		bias_s1 <= k_q == 6'd0;
		mask_s1 <= (l_q == 2'd0) && (k_q > loaded_q);
		last_s1 <= k_q == src_n;
		prod_s2 <= w_rd_q * opnd;
		last_s2 <= last_s1;
		if (state_q == S_FIN || (q_pop && q_item.cmd == mie_pkg::CMD_SAMPLE))
			acc_q <= '0;
		else if (valid_s2)
			acc_q <= acc_q + {{8{prod_s2[31]}}, prod_s2};
	end

	mie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({1'b0, e_r, 16'b0} + {13'b0, sum_q[20:1]}),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			l_q     <= '0;
			src_q   <= 1'b0;
			r_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_item.cmd == mie_pkg::CMD_SAMPLE && q_item.last) begin
						l_q     <= '0;
						src_q   <= 1'b0;
						r_q     <= '0;
						k_q     <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					k_q <= k_q + 6'd1;
					if (k_q == src_n)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (acc_done_q)
						state_q <= S_FIN;
				end
				S_FIN: begin
					k_q <= '0;
					if (!row_last) begin
						r_q     <= r_q + 5'd1;
						state_q <= S_MAC;
					end else if (!is_out) begin
						l_q     <= l_q + 2'd1;
						src_q   <= ~src_q;
						r_q     <= '0;
						state_q <= S_MAC;
					end else begin
						r_q     <= '0;
						state_q <= cfg.softmax ? S_SUM : S_OUT;
					end
				end
				S_SUM: begin
					if (res_last) begin
						r_q     <= '0;
						state_q <= S_OUT;
					end else begin
						r_q <= r_q + 5'd1;
					end
				end
				S_OUT: begin
					state_q <= cfg.softmax ? S_DIV : S_EMIT;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load_out) begin
						if (res_last) begin
							state_q <= S_IDLE;
						end else begin
							r_q     <= r_q + 5'd1;
							state_q <= S_OUT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// address bases, output-layer scores, softmax sum, activation
	always_ff @(posedge clk) begin
		if (q_pop && q_item.cmd == mie_pkg::CMD_SAMPLE) begin
			loaded_q     <= q_item.loaded;
			layer_base_q <= '0;
			row_base_q   <= '0;
		end
		if (state_q == S_FIN) begin
			if (!row_last) begin
				row_base_q <= row_base_q + WA'(mie_pkg::ROW_LEN);
			end else if (!is_out) begin
				layer_base_q <= layer_base_q + WA'(mie_pkg::MAT_WORDS);
				row_base_q   <= layer_base_q + WA'(mie_pkg::MAT_WORDS);
			end
			if (is_out) begin
				zs_q[r_q] <= z;
				// strict compare keeps the lowest index on ties
				if (r_q == 5'd0 || z > zmax_q) begin
					zmax_q <= z;
					best_q <= r_q;
				end
			end
			sum_q <= '0;
		end
		if (state_q == S_SUM)
			sum_q <= sum_q + 21'(e_r);
		if (state_q == S_OUT && !cfg.softmax)
			act_q <= mie_pkg::SIG_TAB[{~zs_q[r_q][15], zs_q[r_q][14:8]}];
		if (state_q == S_DIV && div_done)
			act_q <= (div_quo > 33'd65535) ? 16'hFFFF : div_quo[15:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (load_out)
			result_valid <= 1'b1;
		else if (result_ready)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			neuron_index <= r_q;
			activation   <= act_q;
			best_class   <= res_last ? best_q : 5'd0;
			last         <= res_last;
		end
	end

endmodule

`default_nettype wire

>>> src/mlp_inference_engine_core.sv
// ----------------------------------------------------------------------------
// mlp_inference_engine_core: fixed-point MLP inference engine
// Loads Q4.12 weights, streams sample vectors and returns one Q0.16
// activation per output neuron, with the argmax on the last result.
// ----------------------------------------------------------------------------
// Usage:
//  item channel (item_valid/item_ready): command 0 writes one weight at
//   layer_sel/row_sel/col_sel, command 1 delivers one sample element; the
//   element marked last_element starts the evaluation.
//  result channel (result_valid/result_ready): output_size results in neuron
//   order, last set on the final one, best_class valid there.
//  cfg_write/cfg_index/cfg_data write the six size and mode registers.
//  A four-entry queue sits between intake and execution, so items keep being
//  taken while the engine evaluates, until the queue fills.
//  Weight and element items retire from the queue head while the engine is idle.
//  Evaluation: each neuron runs on the single MAC; then sigmoid output
//  reads each result from the table, softmax first sums over the outputs
//  and then divides each result in the divider.
//  Reset clears control state and loads default sizes; weights and layer
//  values are undefined until written. A stalled receiver holds the result
//  register and the engine waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_inference_engine_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [5:0]         cfg_data,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic               command,
	input  wire logic [1:0]         layer_sel,
	input  wire logic [4:0]         row_sel,
	input  wire logic [5:0]         col_sel,
	input  wire logic signed [15:0] data_value,
	input  wire logic               last_element,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [4:0]              neuron_index,
	output logic [15:0]             activation,
	output logic [4:0]              best_class,
	output logic                    last
);

	logic [2:0] layer_count_q;
	logic [5:0] input_size_q;
	logic [5:0] hidden_one_q;
	logic [5:0] hidden_two_q;
	logic [5:0] output_size_q;
	logic       output_mode_q;

	mie_pkg::cfg_t  cfg;
	mie_pkg::item_t q_item;
	logic           q_valid;
	logic           q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= 3'd3;
			input_size_q  <= 6'd32;
			hidden_one_q  <= 6'd32;
			hidden_two_q  <= 6'd32;
			output_size_q <= 6'd10;
			output_mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mie_pkg::REG_LAYER_COUNT: layer_count_q <= cfg_data[2:0];
				mie_pkg::REG_INPUT_SIZE:  input_size_q  <= cfg_data;
				mie_pkg::REG_HIDDEN_ONE:  hidden_one_q  <= cfg_data;
				mie_pkg::REG_HIDDEN_TWO:  hidden_two_q  <= cfg_data;
				mie_pkg::REG_OUTPUT_SIZE: output_size_q <= cfg_data;
				mie_pkg::REG_OUTPUT_MODE: output_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.nl       = mie_pkg::clamp_layers(layer_count_q);
		cfg.size0    = mie_pkg::clamp_size(input_size_q);
		cfg.size1    = mie_pkg::clamp_size(hidden_one_q);
		cfg.size2    = mie_pkg::clamp_size(hidden_two_q);
		cfg.size_out = mie_pkg::clamp_size(output_size_q);
		cfg.softmax  = output_mode_q;
	end

	mie_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.layer_sel    (layer_sel),
		.row_sel      (row_sel),
		.col_sel      (col_sel),
		.data_value   (data_value),
		.last_element (last_element),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	mie_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.neuron_index (neuron_index),
		.activation   (activation),
		.best_class   (best_class),
		.last         (last)
	);

endmodule

`default_nettype wire

>>> src/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker: port-level checks of the MLP inference engine
// Watches the result channel for stall behavior and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [4:0]  neuron_index,
	input wire logic [15:0] activation,
	input wire logic [4:0]  best_class,
	input wire logic        last
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(activation)
			&& $stable(neuron_index) && $stable(last))
		else $error("stalled result changed");

	// drop best_class on every result but the last
	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> best_class == 5'd0)
		else $error("best_class set on a non-final result");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> best_class <= neuron_index)
		else $error("best_class beyond final neuron");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last ##1 result_valid |->
			neuron_index == $past(neuron_index) + 5'd1)
		else $error("result neuron order broken");

endmodule

bind mlp_inference_engine_core mie_checker u_mie_checker (.*);

`default_nettype wire
